### sv/pftr_pkg.sv
// ----------------------------------------------------------------------------
// pftr_pkg
// shared types and constants for the page frame store text renderer
// ----------------------------------------------------------------------------
`default_nettype none

package pftr_pkg;

  localparam int unsigned ScreenWidth  = 128;
  localparam int unsigned ScreenHeight = 64;
  localparam int unsigned FontWords    = 4096;
  localparam int unsigned FrameBytes   = 1024;
  localparam int unsigned FrameAw      = $clog2(FrameBytes);
  localparam int unsigned FontAw       = $clog2(FontWords);

  localparam logic [7:0]  CharFirst = 8'd32;
  localparam logic [7:0]  CharLast  = 8'd126;
  localparam logic [15:0] GlyphMsb  = 16'h8000;

  localparam logic [4:0] GlyphWidthRst  = 5'd7;
  localparam logic [5:0] GlyphHeightRst = 6'd10;

  typedef enum logic [2:0] {
    OP_SET_CURSOR = 3'd0,
    OP_WRITE_CHAR = 3'd1,
    OP_DRAW_PIXEL = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_LOAD_FONT  = 3'd4,
    OP_READ_BYTE  = 3'd5
  } opcode_e;

  typedef enum logic {
    REG_GLYPH_WIDTH  = 1'b0,
    REG_GLYPH_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_RD_WAIT,
    ST_CLEAR,
    ST_G_FONT,
    ST_G_FWAIT,
    ST_G_RD,
    ST_G_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  char_code;
    logic        pixel_color;
    logic [11:0] font_addr;
    logic [15:0] font_word;
    logic [9:0]  frame_addr;
  } in_word_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] read_data;
    logic [7:0] cursor_col;
  } out_word_t;

  // frame memory port bundle
  typedef struct packed {
    logic               re;
    logic               we;
    logic [FrameAw-1:0] addr;
    logic [7:0]         wdata;
  } frame_req_t;

endpackage

`default_nettype wire

### sv/page_framebuffer_text_renderer.sv
// ----------------------------------------------------------------------------
// page_framebuffer_text_renderer
// page layout monochrome frame store with glyph blitter and byte readout
// ----------------------------------------------------------------------------
// a pixel is read then written back, an off screen pixel skips the frame store;
// read byte waits for the registered read; clear writes one frame byte a cycle;
// a char reads each glyph row from the font store, then the single frame memory
// port does read-modify-write per pixel
// throughput: one word at a time, busy high until its result strobe
// after reset a clearing pass zeroes the frame, busy high
// the result strobe lasts one cycle and the receiver cannot stall
`default_nettype none

module page_framebuffer_text_renderer import pftr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire in_word_t  in_word_i,
  output logic           done_o,
  output out_word_t      out_word_o,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_idx_i,
  input  wire logic [5:0] cfg_wdata_i
);

  // configuration
  logic [4:0] gw_q;
  logic [5:0] gh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= GlyphWidthRst;
      gh_q <= GlyphHeightRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_GLYPH_WIDTH:  gw_q <= cfg_wdata_i[4:0];
        REG_GLYPH_HEIGHT: gh_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  in_word_t  item_q, item_d;
  logic [7:0] cx_q, cx_d, cy_q, cy_d;
  logic [FrameAw:0] clr_q, clr_d;        // clearing counter, ends when its low bits are all ones
  logic [4:0] col_q, col_d;
  logic [5:0] row_q, row_d;
  logic [FontAw-1:0] fbase_q, fbase_d;   // font word index of current row
  logic [15:0] fword_q, fword_d;
  logic       acc_q, acc_d;
  logic [7:0] rd_q, rd_d;
  logic       done_q, done_d;

  frame_req_t fr;
  logic [7:0] frd;
  logic [FontAw-1:0] font_raddr;
  logic [15:0] font_rdata;

  pftr_frame_mem u_frame (.clk_i, .req_i(fr), .rdata_o(frd));

  pftr_font_mem u_font (
    .clk_i,
    .we_i   (start && !busy && in_word_i.opcode == OP_LOAD_FONT),
    .waddr_i(in_word_i.font_addr[FontAw-1:0]),
    .wdata_i(in_word_i.font_word),
    .raddr_i(font_raddr),
    .rdata_o(font_rdata)
  );

  // pixel position of the current glyph pixel or draw pixel
  logic [8:0] px, py;
  logic       pix_on, pix_white;
  logic [7:0] bitmask;
  always_comb begin
    if (item_q.opcode == OP_WRITE_CHAR) begin
      px = {1'b0, cx_q} + {4'd0, col_q};
      py = {1'b0, cy_q} + {3'd0, row_q};
      pix_on = (col_q < 5'd16) && ((fword_q & GlyphMsb) != 16'd0);
      pix_white = pix_on ? item_q.pixel_color : !item_q.pixel_color;
    end else begin
      px = {1'b0, item_q.pos_x};
      py = {1'b0, item_q.pos_y};
      pix_on = 1'b1;
      pix_white = item_q.pixel_color;
    end
    bitmask = 8'd1 << py[2:0];
  end

  logic pix_in;
  logic [FrameAw-1:0] pix_addr;
  assign pix_in   = (px < 9'(ScreenWidth)) && (py < 9'(ScreenHeight));
  assign pix_addr = FrameAw'(px) + FrameAw'({py[8:3], 7'd0} >> (7 - $clog2(ScreenWidth)));

  // char accept check of the code range and against the screen, without wrap
  logic ch_ok;
  logic [13:0] ch_prod;
  logic [FontAw-1:0] ch_base;
  always_comb begin
    ch_ok = (in_word_i.char_code >= CharFirst) && (in_word_i.char_code <= CharLast)
         && ({1'b0, cx_q} + {4'd0, gw_q} <= 9'(ScreenWidth))
         && ({1'b0, cy_q} + {3'd0, gh_q} <= 9'(ScreenHeight));
    // font index wraps at the store size
    ch_prod = {6'd0, in_word_i.char_code - CharFirst} * {8'd0, gh_q};
    ch_base = ch_prod[FontAw-1:0];
  end

  assign font_raddr = fbase_q;

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    cx_d = cx_q; cy_d = cy_q;
    clr_d = clr_q; col_d = col_q; row_d = row_q;
    fbase_d = fbase_q; fword_d = fword_q;
    acc_d = acc_q; rd_d = rd_q;
    done_d = 1'b0;
    fr = '0;
    busy = 1'b1;
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        fr.we   = 1'b1;
        fr.addr = clr_q[FrameAw-1:0];
        clr_d   = clr_q + 1'b1;
        if (clr_q[FrameAw-1:0] == '1) begin
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          item_d = in_word_i;
          acc_d = 1'b0;
          rd_d  = '0;
          state_d = ST_DONE;
          case (opcode_e'(in_word_i.opcode))
            OP_SET_CURSOR: begin
              cx_d = in_word_i.pos_x;
              cy_d = in_word_i.pos_y;
            end
            OP_DRAW_PIXEL: state_d = ST_PIX_RD;
            OP_CLEAR: begin
              clr_d = '0;
              state_d = ST_CLEAR;
            end
            OP_READ_BYTE: begin
              fr.re = 1'b1;
              fr.addr = in_word_i.frame_addr;
              state_d = ST_RD_WAIT;
            end
            OP_WRITE_CHAR: begin
              if (ch_ok) begin
                acc_d = 1'b1;
                row_d = '0;
                col_d = '0;
                fbase_d = ch_base;
                // zero size glyph draws nothing but the cursor still moves by the glyph width
                if (gw_q == '0 || gh_q == '0) begin
                  cx_d = cx_q + {3'd0, gw_q};
                  state_d = ST_DONE;
                end else begin
                  state_d = ST_G_FONT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD_WAIT: begin
        rd_d = frd;
        state_d = ST_DONE;
      end
      ST_PIX_RD: begin
        if (pix_in) begin
          fr.re = 1'b1;
          fr.addr = pix_addr;
          state_d = ST_PIX_WR;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_PIX_WR: begin
        fr.we = 1'b1;
        fr.addr = pix_addr;
        fr.wdata = pix_white ? (frd | bitmask) : (frd & ~bitmask);
        state_d = ST_DONE;
      end
      // font row read issued by address register, data next cycle
      ST_G_FONT: state_d = ST_G_FWAIT;
      ST_G_FWAIT: begin
        fword_d = font_rdata;
        col_d = '0;
        state_d = ST_G_RD;
      end
      ST_G_RD: begin
        fr.re = 1'b1;
        fr.addr = pix_addr;
        state_d = ST_G_WR;
      end
      ST_G_WR: begin
        fr.we = 1'b1;
        fr.addr = pix_addr;
        fr.wdata = pix_white ? (frd | bitmask) : (frd & ~bitmask);
        fword_d = fword_q << 1;
        col_d = col_q + 1'b1;
        state_d = ST_G_RD;
        if (col_q + 1'b1 == gw_q) begin
          row_d = row_q + 1'b1;
          fbase_d = fbase_q + 1'b1;
          state_d = ST_G_FONT;
          if (row_q + 1'b1 == gh_q) begin
            cx_d = cx_q + {3'd0, gw_q};
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        done_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      clr_q   <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_d_unused: begin
      item_q  <= item_d;
      col_q   <= col_d;
      row_q   <= row_d;
      fbase_q <= fbase_d;
      fword_q <= fword_d;
      acc_q   <= acc_d;
      rd_q    <= rd_d;
    end
  end

  // result word, one cycle strobe
  assign done_o = done_q;
  always_comb begin
    out_word_o.accepted   = acc_q;
    out_word_o.read_data  = rd_q;
    out_word_o.cursor_col = cx_q;
  end

  // checks
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without work");
  a_no_start_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("busy during result");

endmodule

`default_nettype wire

### sv/pftr_frame_mem.sv
// ----------------------------------------------------------------------------
// pftr_frame_mem
// frame store, one byte per column per page, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module pftr_frame_mem import pftr_pkg::*; (
  input  wire logic       clk_i,
  input  wire frame_req_t req_i,
  output logic [7:0]      rdata_o
);

  logic [7:0] mem [FrameBytes];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.addr];
    end
  end

endmodule

`default_nettype wire

### sv/pftr_font_mem.sv
// ----------------------------------------------------------------------------
// pftr_font_mem
// glyph row store, undefined until loaded, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module pftr_font_mem import pftr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [FontAw-1:0] waddr_i,
  input  wire logic [15:0]       wdata_i,
  input  wire logic [FontAw-1:0] raddr_i,
  output logic [15:0]            rdata_o
);

  logic [15:0] mem [FontWords];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
